@@ src/mts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg
// Types and codes shared by the minimum-tracking stack: request and response
// beat layouts, operation modes and error codes.
// ----------------------------------------------------------------------------
package mts_pkg;

   localparam int VALUE_WIDTH = 32;

   // Operation modes carried in a request beat.
   localparam logic [1:0] MODE_PUSH = 2'd0;
   localparam logic [1:0] MODE_POP  = 2'd1;
   localparam logic [1:0] MODE_PEEK = 2'd2;

   // Error codes reported in a response beat.
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_PUSH_FULL  = 2'd1;
   localparam logic [1:0] ERR_POP_EMPTY  = 2'd2;

   typedef struct packed {
      logic [1:0]                    mode;
      logic signed [VALUE_WIDTH-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] top_value;
      logic signed [VALUE_WIDTH-1:0] min_value;
      logic                          is_empty;
      logic [1:0]                    error_code;
   } rsp_type;

endpackage

@@ src/mts_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_ram
// Simple dual-port synchronous memory: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module mts_ram import mts_pkg::*; #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/min_tracking_stack_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_core
// Bounded LIFO stack of signed 32-bit values that reports its current minimum
// after every operation.
// ----------------------------------------------------------------------------
// Each request beat pushes a value, pops the top, or peeks; each produces
// exactly one response beat with the top value, the minimum, an empty flag
// and an error code (top and minimum read as zero when the stack is empty).
// The entries live in two synchronous memories, one for values and one for
// the running minima, while the current top of each is held in a register.
// A push, a peek or an ignored pop is answered straight from the idle state,
// so such beats can be accepted on consecutive cycles while the response
// side does not stall. A pop that removes an entry passes through the fetch
// and reply states: the new tops have to be fetched from the memories, whose
// read port is registered, and are loaded into the top registers before the
// response is formed. The response sits in an output register; a new request
// is taken while the previous response is still waiting only if it can leave
// in that same cycle. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module min_tracking_stack_core import mts_pkg::*; #(
   parameter int STACK_DEPTH = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int INDEX_WIDTH = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(STACK_DEPTH + 1);
   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(STACK_DEPTH);
   localparam logic [COUNT_WIDTH-1:0] ONE_COUNT  = COUNT_WIDTH'(1);

   // Control states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_REPLY = 2'd2;

   logic [1:0]                    state_ff,   state_in;
   logic [COUNT_WIDTH-1:0]        count_ff,   count_in;
   logic [COUNT_WIDTH-1:0]        mcount_ff,  mcount_in;
   logic signed [VALUE_WIDTH-1:0] top_ff,     top_in;
   logic signed [VALUE_WIDTH-1:0] mtop_ff,    mtop_in;
   logic [1:0]                    err_ff,     err_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_ff,     rsp_in;

   logic                          slot_free;
   logic                          accept;
   logic                          v_wr_en;
   logic                          m_wr_en;
   logic [COUNT_WIDTH-1:0]        v_rd_full;
   logic [COUNT_WIDTH-1:0]        m_rd_full;
   logic [INDEX_WIDTH-1:0]        v_rd_addr;
   logic [INDEX_WIDTH-1:0]        m_rd_addr;
   logic [VALUE_WIDTH-1:0]        v_rd_data;
   logic [VALUE_WIDTH-1:0]        m_rd_data;

   // Forms a response beat from the stack state after an operation.
   function automatic rsp_type make_rsp(
      input logic [COUNT_WIDTH-1:0]        count,
      input logic [COUNT_WIDTH-1:0]        mcount,
      input logic signed [VALUE_WIDTH-1:0] top,
      input logic signed [VALUE_WIDTH-1:0] mtop,
      input logic [1:0]                    err
   );
      rsp_type r;
      r.top_value  = (count != '0) ? top : '0;
      r.min_value  = ((count != '0) && (mcount != '0)) ? mtop : '0;
      r.is_empty   = (count == '0);
      r.error_code = err;
      return r;
   endfunction

   // Handshake: requests are taken only in idle with room in the output.
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && slot_free);
   assign accept    = req_valid && !req_stall;

   // Next-state logic for the stack and the response register.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      mcount_in    = mcount_ff;
      top_in       = top_ff;
      mtop_in      = mtop_ff;
      err_in       = err_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      v_wr_en      = 1'b0;
      m_wr_en      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               err_in = ERR_NONE;
               case (req_data.mode)
                  MODE_PUSH: begin
                     if (count_ff == FULL_COUNT) begin
                        err_in = ERR_PUSH_FULL;
                     end else begin
                        v_wr_en  = 1'b1;
                        count_in = count_ff + ONE_COUNT;
                        top_in   = req_data.push_value;
                        if ((mcount_ff == '0) || (req_data.push_value <= mtop_ff)) begin
                           if (mcount_ff != FULL_COUNT) begin
                              m_wr_en   = 1'b1;
                              mcount_in = mcount_ff + ONE_COUNT;
                              mtop_in   = req_data.push_value;
                           end
                        end
                     end
                  end
                  MODE_POP: begin
                     if (count_ff == '0) begin
                        err_in = ERR_POP_EMPTY;
                     end else begin
                        count_in = count_ff - ONE_COUNT;
                        if ((mcount_ff != '0) && (mtop_ff == top_ff)) begin
                           mcount_in = mcount_ff - ONE_COUNT;
                        end
                        state_in = ST_FETCH;
                     end
                  end
                  default: begin
                     // Peek and the unused mode leave the stack unchanged.
                  end
               endcase
               if (state_in == ST_IDLE) begin
                  rsp_in       = make_rsp(count_in, mcount_in, top_in, mtop_in, err_in);
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_FETCH: begin
            // The new tops arrive from the memories this cycle.
            top_in   = v_rd_data;
            mtop_in  = m_rd_data;
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (slot_free) begin
               rsp_in       = make_rsp(count_ff, mcount_ff, top_ff, mtop_ff, err_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Read addresses point at the new top entry after a pop.
   assign v_rd_full = count_in - ONE_COUNT;
   assign m_rd_full = mcount_in - ONE_COUNT;
   assign v_rd_addr = v_rd_full[INDEX_WIDTH-1:0];
   assign m_rd_addr = m_rd_full[INDEX_WIDTH-1:0];

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         mcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mcount_ff    <= mcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      top_ff  <= top_in;
      mtop_ff <= mtop_in;
      err_ff  <= err_in;
      rsp_ff  <= rsp_in;
   end

   // Value stack memory.
   mts_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (v_wr_en),
      .wr_addr (count_ff[INDEX_WIDTH-1:0]),
      .wr_data (req_data.push_value),
      .rd_addr (v_rd_addr),
      .rd_data (v_rd_data)
   );

   // Running-minimum stack memory.
   mts_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_min_ram (
      .clock   (clock),
      .wr_en   (m_wr_en),
      .wr_addr (mcount_ff[INDEX_WIDTH-1:0]),
      .wr_data (req_data.push_value),
      .rd_addr (m_rd_addr),
      .rd_data (m_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ sim/min_tracking_stack_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_core_tb
// Self-checking bench for the minimum-tracking stack. A short scripted run
// covers the empty, extreme and duplicate-minimum cases. Two fill-and-drain
// passes push the stack to its full depth, one with all values equal so the
// minimum stack fills as well. Random segments then mix pushes, pops and
// peeks with varying bias. Every response beat is compared field by field
// against the script's expected values or a behavioral stack model kept in
// the bench. Both channels idle at random, except during one long stretch.
// ----------------------------------------------------------------------------
module min_tracking_stack_core_tb;
   import mts_pkg::*;

   localparam int          DEPTH        = 256;
   localparam int          RANDOM_BEATS = 700;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          DRAIN_CYCLES = 10;
   localparam logic [1:0]  MODE_UNUSED  = 2'd3;

   typedef struct {
      req_type op;
      bit      fixed;
      rsp_type want;
   } script_row;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Bench-side copy of the two stacks.
   logic signed [VALUE_WIDTH-1:0] value_mirror [DEPTH];
   logic signed [VALUE_WIDTH-1:0] minima_mirror[DEPTH];
   int unsigned                   value_depth;
   int unsigned                   minima_depth;

   rsp_type   expected_status[$];
   script_row script[$];
   int        mismatch_count = 0;
   int        cycle_count    = 0;
   bit        steady         = 1'b0;

   min_tracking_stack_core #(.STACK_DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Apply one operation to the mirrored stacks and return the status beat.
   function automatic rsp_type stack_step(input req_type op);
      rsp_type outcome;
      logic signed [VALUE_WIDTH-1:0] v;
      outcome = '0;
      v = op.push_value;
      case (op.mode)
         MODE_PUSH: begin
            if (value_depth >= DEPTH) begin
               outcome.error_code = ERR_PUSH_FULL;
            end else begin
               value_mirror[value_depth] = v;
               value_depth++;
               // Equal values go on the minimum stack too, so duplicates survive a pop.
               if (minima_depth == 0 || v <= minima_mirror[minima_depth-1]) begin
                  if (minima_depth < DEPTH) begin
                     minima_mirror[minima_depth] = v;
                     minima_depth++;
                  end
               end
            end
         end
         MODE_POP: begin
            if (value_depth == 0) begin
               outcome.error_code = ERR_POP_EMPTY;
            end else begin
               if (minima_depth > 0 &&
                   minima_mirror[minima_depth-1] == value_mirror[value_depth-1])
                  minima_depth--;
               value_depth--;
            end
         end
         default: ;
      endcase
      if (value_depth > 0) begin
         outcome.top_value = value_mirror[value_depth-1];
         if (minima_depth > 0)
            outcome.min_value = minima_mirror[minima_depth-1];
      end
      outcome.is_empty = (value_depth == 0);
      return outcome;
   endfunction

   // Drive one request beat, after a random gap unless steady is set, and log
   // its expectation once the beat is taken. Entered and left at a falling edge.
   task automatic send_beat(input req_type op, input bit fixed, input rsp_type want);
      rsp_type predicted;
      while (!steady && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= op;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predicted = stack_step(op);
      expected_status.push_back(fixed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic send_op(input logic [1:0] mode, input logic [31:0] value);
      req_type op;
      op.mode       = mode;
      op.push_value = value;
      send_beat(op, 1'b0, '0);
   endtask

   // Hold the request side quiet until every response has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_status.size() != 0)
         @(negedge clock);
   endtask

   task automatic add_row(input logic [1:0] mode, input logic [31:0] value, input bit fixed,
                          input logic [31:0] top, input logic [31:0] low,
                          input logic empty, input logic [1:0] err);
      script_row row;
      row.op.mode          = mode;
      row.op.push_value    = value;
      row.fixed            = fixed;
      row.want.top_value   = top;
      row.want.min_value   = low;
      row.want.is_empty    = empty;
      row.want.error_code  = err;
      script.push_back(row);
   endtask

   // Push the stack to full, push once more, then pop past empty.
   task automatic fill_and_drain(input bit all_equal);
      logic [31:0] level;
      level = $urandom;
      for (int i = 0; i < DEPTH + 1; i++)
         send_op(MODE_PUSH, all_equal ? level : $urandom);
      for (int i = 0; i < DEPTH + 1; i++)
         send_op(MODE_POP, $urandom);
   endtask

   // Random segments, each with its own push bias and value style.
   task automatic run_random(input int count);
      int          seg_left;
      int          push_pct;
      int          value_style;
      int          roll;
      logic [1:0]  mode;
      logic [31:0] value;
      seg_left    = 0;
      push_pct    = 50;
      value_style = 0;
      for (int i = 0; i < count; i++) begin
         if (seg_left == 0) begin
            seg_left    = $urandom_range(20, 80);
            roll        = $urandom_range(0, 2);
            push_pct    = (roll == 0) ? 80 : (roll == 1) ? 50 : 20;
            value_style = $urandom_range(0, 2);
         end
         seg_left--;
         case (value_style)
            0:       value = $urandom;
            1:       value = $urandom_range(0, 8) - 4;
            default: begin
               roll  = $urandom_range(0, 3);
               value = (roll == 0) ? 32'h8000_0000 : (roll == 1) ? 32'h7fff_ffff :
                       (roll == 2) ? 32'h0000_0000 : 32'hffff_ffff;
            end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < push_pct) begin
            mode = MODE_PUSH;
         end else begin
            roll = $urandom_range(0, 19);
            mode = (roll < 16) ? MODE_POP : (roll < 19) ? MODE_PEEK : MODE_UNUSED;
            if (value_style != 0)
               value = $urandom;
         end
         send_op(mode, value);
      end
   endtask

   // Response side backpressure.
   always @(negedge clock)
      rsp_stall <= !steady && ($urandom_range(0, 99) < 30);

   // Compare each response beat with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status.size() == 0) begin
            $error("unexpected response beat: %p", rsp_data);
            mismatch_count++;
         end else begin
            want = expected_status.pop_front();
            if (rsp_data.top_value !== want.top_value) begin
               $error("top_value expected %0d actual %0d", want.top_value, rsp_data.top_value);
               mismatch_count++;
            end
            if (rsp_data.min_value !== want.min_value) begin
               $error("min_value expected %0d actual %0d", want.min_value, rsp_data.min_value);
               mismatch_count++;
            end
            if (rsp_data.is_empty !== want.is_empty) begin
               $error("is_empty expected %0d actual %0d", want.is_empty, rsp_data.is_empty);
               mismatch_count++;
            end
            if (rsp_data.error_code !== want.error_code) begin
               $error("error_code expected %0d actual %0d", want.error_code,
                      rsp_data.error_code);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      value_depth  = 0;
      minima_depth = 0;

      // Scripted cases: empty stack, extremes, duplicate minima, unused mode.
      add_row(MODE_PEEK,   32'h0000_0000, 1, 32'h0,          32'h0,          1, ERR_NONE);
      add_row(MODE_POP,    32'h1234_5678, 1, 32'h0,          32'h0,          1, ERR_POP_EMPTY);
      add_row(MODE_UNUSED, 32'hffff_ffff, 1, 32'h0,          32'h0,          1, ERR_NONE);
      add_row(MODE_PUSH,   32'h7fff_ffff, 1, 32'h7fff_ffff,  32'h7fff_ffff,  0, ERR_NONE);
      add_row(MODE_PUSH,   32'h8000_0000, 1, 32'h8000_0000,  32'h8000_0000,  0, ERR_NONE);
      add_row(MODE_PUSH,   32'h8000_0000, 1, 32'h8000_0000,  32'h8000_0000,  0, ERR_NONE);
      add_row(MODE_PUSH,   32'h0000_0005, 1, 32'h0000_0005,  32'h8000_0000,  0, ERR_NONE);
      add_row(MODE_POP,    32'h0000_0000, 1, 32'h8000_0000,  32'h8000_0000,  0, ERR_NONE);
      add_row(MODE_POP,    32'h0000_0000, 1, 32'h8000_0000,  32'h8000_0000,  0, ERR_NONE);
      add_row(MODE_POP,    32'h0000_0000, 1, 32'h7fff_ffff,  32'h7fff_ffff,  0, ERR_NONE);
      add_row(MODE_PUSH,   32'h0000_0000, 0, '0, '0, 0, ERR_NONE);
      add_row(MODE_PUSH,   32'hffff_ffff, 0, '0, '0, 0, ERR_NONE);
      add_row(MODE_PUSH,   32'hffff_ffff, 0, '0, '0, 0, ERR_NONE);
      add_row(MODE_PEEK,   32'h5555_aaaa, 0, '0, '0, 0, ERR_NONE);
      add_row(MODE_POP,    32'haaaa_5555, 0, '0, '0, 0, ERR_NONE);
      add_row(MODE_UNUSED, 32'h0f0f_f0f0, 0, '0, '0, 0, ERR_NONE);
      add_row(MODE_POP,    32'h0000_0000, 0, '0, '0, 0, ERR_NONE);
      add_row(MODE_PUSH,   32'h0000_0007, 0, '0, '0, 0, ERR_NONE);
      add_row(MODE_PUSH,   32'h0000_0007, 0, '0, '0, 0, ERR_NONE);
      add_row(MODE_PUSH,   32'h0000_0003, 0, '0, '0, 0, ERR_NONE);
      add_row(MODE_POP,    32'h0000_0000, 0, '0, '0, 0, ERR_NONE);
      add_row(MODE_POP,    32'h0000_0000, 0, '0, '0, 0, ERR_NONE);
      add_row(MODE_POP,    32'h0000_0000, 0, '0, '0, 0, ERR_NONE);
      add_row(MODE_POP,    32'h0000_0000, 0, '0, '0, 0, ERR_NONE);
      add_row(MODE_POP,    32'h0000_0000, 1, 32'h0,          32'h0,          1, ERR_NONE);
      add_row(MODE_POP,    32'h0000_0000, 1, 32'h0,          32'h0,          1, ERR_POP_EMPTY);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i])
         send_beat(script[i].op, script[i].fixed, script[i].want);
      wait_drained();

      // Random values to full depth, then equal values with no idling at all.
      fill_and_drain(1'b0);
      wait_drained();
      steady = 1'b1;
      fill_and_drain(1'b1);
      steady = 1'b0;

      run_random(RANDOM_BEATS);

      req_valid <= 1'b0;
      while (expected_status.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && expected_status.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
